### hw/rtl/wrm_pkg.sv
// Shared constants, codes and types for the wildcard pattern matcher.
// Depends on nothing; every other file of the block imports it, apart from wrm_rsp_if.
`timescale 1ns / 1ps

package wrm_pkg;

    localparam int PATTERN_TOKENS = 16;
    localparam int CNT_W          = $clog2(PATTERN_TOKENS + 1);
    localparam int CFG_W          = 5;
    localparam int MODE_W         = 2;
    localparam int IDX_W          = 4;
    localparam int CHAR_W         = 8;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMPTY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    // Signals passed from one cell to the next along the chain.
    typedef struct packed {
        logic start;
        logic adv;
        logic clos;
    } wrm_link_t;

endpackage

### hw/rtl/wrm_req_if.sv
// Request channel of the matcher: valid/ready handshake and the request fields.
// Depends on wrm_pkg for the field widths.
`timescale 1ns / 1ps

interface wrm_req_if
    import wrm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  token_index;
    logic [CHAR_W-1:0] token_char;
    logic              token_any;
    logic              token_star;
    logic [CHAR_W-1:0] text_char;
    logic              text_last;

    modport source (
        output valid, mode, token_index, token_char, token_any, token_star,
               text_char, text_last,
        input  ready
    );

    modport sink (
        input  valid, mode, token_index, token_char, token_any, token_star,
               text_char, text_last,
        output ready
    );
endinterface

### hw/rtl/wrm_rsp_if.sv
// Response channel of the matcher: valid/ready handshake and the match flag.
// Depends on nothing beyond the wrm_pkg compile order.
`timescale 1ns / 1ps

interface wrm_rsp_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (
        output valid, matched,
        input  ready
    );

    modport sink (
        input  valid, matched,
        output ready
    );
endinterface

### hw/rtl/wrm_cell.sv
// One pattern position of the matcher chain: holds a token and its active bit.
// Depends on wrm_pkg for widths and the link type.
`timescale 1ns / 1ps

module wrm_cell
    import wrm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_en,
    input  logic [CHAR_W-1:0] token_char,
    input  logic              token_any,
    input  logic              token_star,
    input  logic              en,
    input  logic              in_string,
    input  logic              step_en,
    input  logic [CHAR_W-1:0] text_char,
    input  wrm_link_t         link_in,
    output wrm_link_t         link_out,
    output logic              fin
);

    logic [CHAR_W-1:0] char_reg;
    logic              any_reg;
    logic              star_reg;
    logic              act_reg;
    logic              act_next;
    logic              cur;
    logic              hit;
    logic              raw;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            char_reg <= token_char;
            any_reg  <= token_any;
            star_reg <= token_star;
        end
    end

    always_comb
    begin
        cur            = in_string ? act_reg : link_in.start;
        hit            = en && cur && (any_reg || (char_reg == text_char));
        raw            = (hit && star_reg) || link_in.adv;
        fin            = raw || link_in.clos;
        link_out.start = link_in.start && star_reg && en;
        link_out.adv   = hit && !star_reg;
        link_out.clos  = fin && star_reg && en;
        act_next       = step_en ? fin : act_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule

### hw/rtl/wildcard_regex_matcher_unit.sv
// Top level of the wildcard pattern matcher: token store, cell chain, result register.
// Depends on wrm_pkg, wrm_req_if, wrm_rsp_if and wrm_cell.
`timescale 1ns / 1ps

// The matcher checks whole texts against a pattern of literal bytes, '.' and '*'.
// Requests on req load one pattern token, carry one text byte, or ask whether
// the empty text matches. The register written through cfg_wr_en/cfg_wr_data
// sets how many tokens are in use; the user must write it only while the block is
// idle, which the block itself does not enforce. Each pattern position is one cell
// of a chain; a text byte updates every cell in the cycle it is accepted, so one
// request is taken in every cycle while req.ready is high. A response on rsp carries
// the match flag and appears in the cycle after the request that ends a text or asks
// for the empty text; other requests give none. The response register frees in the
// cycle it is taken, so a stalled receiver holds req.ready low only while a response
// is waiting and not being taken. Reset clears the active positions, the token
// count and any text in progress; the pattern tokens stay undefined until loaded.
module wildcard_regex_matcher_unit
    import wrm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    wrm_req_if.sink          req,
    wrm_rsp_if.source        rsp,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    in_string_reg;
    logic                    in_string_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic                    rsp_matched_reg;
    logic                    rsp_matched_next;
    logic                    accept;
    logic                    step_en;
    logic [PATTERN_TOKENS:0] start_vec;
    logic [PATTERN_TOKENS:0] fin_vec;
    wrm_link_t               link [PATTERN_TOKENS+1];

    assign req.ready   = !rsp_valid_reg || rsp.ready;
    assign accept      = req.valid && req.ready;
    assign step_en     = accept && (req.mode == MODE_TEXT);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.matched = rsp_matched_reg;

    assign link[0] = '{start: 1'b1, adv: 1'b0, clos: 1'b0};

    for (genvar j = 0; j < PATTERN_TOKENS; j++)
    begin : g_cell
        logic load_en;
        logic en;

        assign load_en      = accept && (req.mode == MODE_LOAD) && (int'(req.token_index) == j);
        assign en           = int'(cnt_reg) > j;
        assign start_vec[j] = link[j].start;

        wrm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load_en    (load_en),
            .token_char (req.token_char),
            .token_any  (req.token_any),
            .token_star (req.token_star),
            .en         (en),
            .in_string  (in_string_reg),
            .step_en    (step_en),
            .text_char  (req.text_char),
            .link_in    (link[j]),
            .link_out   (link[j+1]),
            .fin        (fin_vec[j])
        );
    end

    assign start_vec[PATTERN_TOKENS] = link[PATTERN_TOKENS].start;
    assign fin_vec[PATTERN_TOKENS]   = link[PATTERN_TOKENS].adv || link[PATTERN_TOKENS].clos;

    always_comb
    begin
        cnt_next         = cnt_reg;
        in_string_next   = in_string_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_matched_next = rsp_matched_reg;
        if (cfg_wr_en)
        begin
            if (int'(cfg_wr_data) > PATTERN_TOKENS)
            begin
                cnt_next = CNT_W'(PATTERN_TOKENS);
            end
            else
            begin
                cnt_next = CNT_W'(cfg_wr_data);
            end
            in_string_next = 1'b0;
        end
        if (accept)
        begin
            unique case (req.mode)
                MODE_LOAD:
                begin
                    in_string_next = 1'b0;
                end
                MODE_TEXT:
                begin
                    in_string_next = !req.text_last;
                    if (req.text_last)
                    begin
                        rsp_valid_next   = 1'b1;
                        rsp_matched_next = fin_vec[cnt_reg];
                    end
                end
                MODE_EMPTY:
                begin
                    in_string_next   = 1'b0;
                    rsp_valid_next   = 1'b1;
                    rsp_matched_next = start_vec[cnt_reg];
                end
                MODE_NONE:
                begin
                    in_string_next = in_string_reg;
                end
                default:
                begin
                    in_string_next = in_string_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            in_string_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            in_string_reg <= in_string_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_matched_reg <= rsp_matched_next;
    end

`ifndef SYNTHESIS
    a_last_gives_rsp : assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.mode == MODE_TEXT) && req.text_last |=> rsp.valid)
        else $error("text end did not produce a response");

    a_cfg_ends_text : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !in_string_reg)
        else $error("configuration write left a text in progress");

    a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) <= PATTERN_TOKENS)
        else $error("token count beyond the pattern length");
`endif

endmodule

### dv/wildcard_regex_matcher_unit_tb.sv
// Self-checking testbench for wildcard_regex_matcher_unit: random and directed pattern loads,
// text streams and empty-text queries, with idle gaps and response back-pressure.
// Depends on wrm_pkg, wrm_req_if, wrm_rsp_if and the matcher RTL.
`timescale 1ns / 1ps

class match_predictor;
    logic [7:0]                      tok_char [wrm_pkg::PATTERN_TOKENS];
    bit                              tok_any  [wrm_pkg::PATTERN_TOKENS];
    bit                              tok_star [wrm_pkg::PATTERN_TOKENS];
    logic [wrm_pkg::PATTERN_TOKENS:0] live;
    bit                              in_text;
    int unsigned                     count;
    bit                              expected_matched [$];
    int                              fail_count;

    function new();
        for (int i = 0; i < wrm_pkg::PATTERN_TOKENS; i++)
        begin
            tok_char[i] = '0;
            tok_any[i]  = 1'b0;
            tok_star[i] = 1'b0;
        end
        live       = '0;
        in_text    = 1'b0;
        count      = 0;
        fail_count = 0;
    endfunction

    function logic [wrm_pkg::PATTERN_TOKENS:0] follow_stars(
        logic [wrm_pkg::PATTERN_TOKENS:0] v);
        logic [wrm_pkg::PATTERN_TOKENS:0] r;
        r = v;
        for (int j = 0; j < count; j++)
        begin
            if (r[j] && tok_star[j])
                r[j+1] = 1'b1;
        end
        return r;
    endfunction

    function void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR at %0t ns: %s", $time, msg);
    endfunction

    function void write_count(logic [wrm_pkg::CFG_W-1:0] v);
        count   = (v > wrm_pkg::PATTERN_TOKENS) ? wrm_pkg::PATTERN_TOKENS : v;
        in_text = 1'b0;
    endfunction

    function void take_request(logic [1:0] mode, logic [3:0] idx, logic [7:0] tch,
                               logic tany, logic tstar, logic [7:0] xch, logic last);
        logic [wrm_pkg::PATTERN_TOKENS:0] nxt;
        nxt = '0;
        case (mode)
            wrm_pkg::MODE_LOAD:
            begin
                if (int'(idx) < wrm_pkg::PATTERN_TOKENS)
                begin
                    tok_char[idx] = tch;
                    tok_any[idx]  = tany;
                    tok_star[idx] = tstar;
                end
                in_text = 1'b0;
            end
            wrm_pkg::MODE_EMPTY:
            begin
                in_text = 1'b0;
                live    = follow_stars(1);
                expected_matched.push_back(live[count]);
            end
            wrm_pkg::MODE_TEXT:
            begin
                if (!in_text)
                    live = follow_stars(1);
                for (int j = 0; j < count; j++)
                begin
                    if (live[j] && (tok_any[j] || tok_char[j] == xch))
                    begin
                        if (tok_star[j])
                            nxt[j] = 1'b1;
                        else
                            nxt[j+1] = 1'b1;
                    end
                end
                live = follow_stars(nxt);
                if (last)
                begin
                    in_text = 1'b0;
                    expected_matched.push_back(live[count]);
                end
                else
                begin
                    in_text = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void check_matched(logic act);
        bit exp_v;
        if (expected_matched.size() == 0)
        begin
            note_failure($sformatf("response with no request waiting, matched=%0b", act));
            return;
        end
        exp_v = expected_matched.pop_front();
        if (act !== exp_v)
            note_failure($sformatf("matched: expected %0b, got %0b", exp_v, act));
    endfunction

    function int pending();
        return expected_matched.size();
    endfunction

    function void close_out();
        if (expected_matched.size() != 0)
            note_failure($sformatf("%0d responses never arrived", expected_matched.size()));
    endfunction
endclass

module wildcard_regex_matcher_unit_tb;
    import wrm_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    wrm_req_if req_if ();
    wrm_rsp_if rsp_if ();

    match_predictor pred;
    int             sent_items;
    bit             steady;
    int             tokens_in_use;
    logic [CFG_W-1:0] count_raw;
    logic [7:0]     pat_char [PATTERN_TOKENS];
    bit             pat_any  [PATTERN_TOKENS];
    bit             pat_star [PATTERN_TOKENS];

    wildcard_regex_matcher_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
                pred.check_matched(rsp_if.matched);
            if (req_if.valid && req_if.ready)
                pred.take_request(req_if.mode, req_if.token_index, req_if.token_char,
                                  req_if.token_any, req_if.token_star, req_if.text_char,
                                  req_if.text_last);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] pick_char(bit wide);
        if (wide)
            return $urandom_range(0, 255);
        else
            return 8'h61 + $urandom_range(0, 3);
    endfunction

    initial
    begin : rsp_pacing
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                @(negedge clk);
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(negedge clk);
            end
            else
            begin
                hold = gap_len();
                if (hold > 0)
                begin
                    @(negedge clk);
                    rsp_if.ready <= 1'b0;
                    repeat (hold - 1) @(negedge clk);
                end
                @(negedge clk);
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_req(input logic [1:0] mode, input logic [3:0] idx,
                            input logic [7:0] tch, input logic tany, input logic tstar,
                            input logic [7:0] xch, input logic last);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid       <= 1'b1;
        req_if.mode        <= mode;
        req_if.token_index <= idx;
        req_if.token_char  <= tch;
        req_if.token_any   <= tany;
        req_if.token_star  <= tstar;
        req_if.text_char   <= xch;
        req_if.text_last   <= last;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (mode != MODE_NONE)
            sent_items++;
    endtask

    task automatic set_token(input int i, input logic [7:0] ch, input bit any, input bit star);
        pat_char[i] = ch;
        pat_any[i]  = any;
        pat_star[i] = star;
        send_req(MODE_LOAD, i, ch, any, star, $urandom_range(0, 255), $urandom_range(0, 1));
    endtask

    task automatic load_token(input int i, input bit wide);
        set_token(i, pick_char(wide), $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 35);
    endtask

    task automatic send_byte(input logic [7:0] ch, input logic last);
        send_req(MODE_TEXT, $urandom_range(0, 15), $urandom_range(0, 255),
                 $urandom_range(0, 1), $urandom_range(0, 1), ch, last);
    endtask

    task automatic send_empty();
        send_req(MODE_EMPTY, $urandom_range(0, 15), $urandom_range(0, 255),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
                 $urandom_range(0, 1));
    endtask

    task automatic send_unused();
        send_req(MODE_NONE, $urandom_range(0, 15), $urandom_range(0, 255),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
                 $urandom_range(0, 1));
    endtask

    task automatic go_idle();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pred.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] v);
        go_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        pred.write_count(v);
        @(negedge clk);
        cfg_wr_en     <= 1'b0;
        count_raw     = v;
        tokens_in_use = (v > PATTERN_TOKENS) ? PATTERN_TOKENS : v;
    endtask

    task automatic send_list(ref logic [7:0] txt [$], input bit cut, input bit wide);
        for (int k = 0; k < txt.size(); k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_unused();
            send_byte(txt[k], (k == txt.size() - 1) && !cut);
        end
        if (cut)
        begin
            case ($urandom_range(0, 2))
                0:       send_empty();
                1:       load_token($urandom_range(0, PATTERN_TOKENS - 1), wide);
                default: write_count(count_raw);
            endcase
        end
    endtask

    task automatic send_text(input bit mutate, input bit wide, input bit cut);
        logic [7:0] txt [$];
        int         reps;
        int         p;
        for (int j = 0; j < tokens_in_use; j++)
        begin
            reps = pat_star[j] ? $urandom_range(0, 3) : 1;
            repeat (reps)
                txt.push_back(pat_any[j] ? pick_char(wide) : pat_char[j]);
        end
        if (mutate)
        begin
            p = $urandom_range(0, txt.size());
            case ($urandom_range(0, 2))
                0:
                begin
                    if (p < txt.size())
                        txt[p] = pick_char(wide);
                end
                1:
                begin
                    if (p < txt.size())
                        txt.delete(p);
                end
                default: txt.insert(p, pick_char(wide));
            endcase
        end
        if (txt.size() == 0)
        begin
            if (!cut)
                send_empty();
            return;
        end
        send_list(txt, cut, wide);
    endtask

    task automatic send_noise();
        logic [7:0] txt [$];
        repeat ($urandom_range(1, 6))
            txt.push_back($urandom_range(0, 255));
        send_list(txt, 1'b0, 1'b1);
    endtask

    initial
    begin : stimulus
        int         r;
        bit         wide;
        logic [7:0] dtext [$];
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_if.valid       = 1'b0;
        req_if.mode        = MODE_LOAD;
        req_if.token_index = '0;
        req_if.token_char  = '0;
        req_if.token_any   = 1'b0;
        req_if.token_star  = 1'b0;
        req_if.text_char   = '0;
        req_if.text_last   = 1'b0;
        rsp_if.ready       = 1'b0;
        pred               = new();
        sent_items         = 0;
        steady             = 1'b0;
        tokens_in_use      = 0;
        count_raw          = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The empty pattern matches only the empty text.
        write_count(0);
        send_empty();
        send_byte(8'h00, 1'b1);
        send_unused();

        set_token(0, 8'h00, 1'b0, 1'b1);
        set_token(1, 8'h5A, 1'b1, 1'b0);
        set_token(2, 8'hFF, 1'b0, 1'b0);
        set_token(3, 8'h61, 1'b0, 1'b1);
        write_count(4);
        send_empty();
        dtext = '{8'h00, 8'h7E, 8'hFF};
        send_list(dtext, 1'b0, 1'b0);
        dtext = '{8'h55, 8'hFF, 8'h61, 8'h61};
        send_list(dtext, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_empty();
        send_byte(8'h37, 1'b0);
        send_unused();
        send_byte(8'hFF, 1'b1);

        while (sent_items < 1470)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                write_count(0);
            else if (r == 1)
                write_count(PATTERN_TOKENS);
            else if (r == 2)
                write_count($urandom_range(PATTERN_TOKENS + 1, 31));
            else if (r == 3)
                write_count($urandom_range(11, PATTERN_TOKENS - 1));
            else
                write_count($urandom_range(1, 10));
            steady = ($urandom_range(0, 3) == 0);
            wide   = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < tokens_in_use; i++)
                load_token(i, wide);
            if ($urandom_range(0, 3) == 0)
            begin
                for (int i = tokens_in_use; i < PATTERN_TOKENS; i++)
                    load_token(i, 1'b1);
            end
            repeat ($urandom_range(4, 12))
            begin
                r = $urandom_range(0, 19);
                if (r < 10)
                    send_text(1'b0, wide, 1'b0);
                else if (r < 13)
                    send_text(1'b1, wide, 1'b0);
                else if (r < 15)
                    send_empty();
                else if (r < 17)
                    send_noise();
                else if (r < 19)
                    send_text($urandom_range(0, 1), wide, 1'b1);
                else
                    send_unused();
            end
        end

        go_idle();
        repeat (8) @(posedge clk);
        pred.close_out();
        if (pred.fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
